[rtl/iqgcal_pkg.sv]
// ----------------------------------------------------------------------------
// iqgcal_pkg
// Shared types and constants for the ADC I/Q gain mismatch calibration unit:
// transaction structs, op codes, sequencer states and arithmetic widths.
// ----------------------------------------------------------------------------
package iqgcal_pkg;

   // widths
   localparam int ACC_W        = 32;
   localparam int GAIN_W       = 6;
   localparam int FIELD_W      = 2 * GAIN_W;
   localparam int CHAIN_W      = 2;
   localparam int OP_W         = 2;
   localparam int NUMCH_W      = 2;
   localparam int GAIN_SHIFT   = 5;
   localparam int MAX_CHAINS_DEF = 3;

   // op codes
   localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
   localparam logic [OP_W-1:0] OP_CALIB = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // reset value of the chain count register
   localparam logic [NUMCH_W-1:0] NUMCH_RESET = 2'd3;

   // request transaction
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [CHAIN_W-1:0] chain;
      logic [ACC_W-1:0]   meas_i_odd;
      logic [ACC_W-1:0]   meas_i_even;
      logic [ACC_W-1:0]   meas_q_odd;
      logic [ACC_W-1:0]   meas_q_even;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [CHAIN_W-1:0] out_chain;
      logic [FIELD_W-1:0] gain_field;
      logic               updated;
      logic               enable_corr;
      logic               last;
   } rsp_type;

   // calibration sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_I,
      ST_DIV_Q
   } cal_state_type;

endpackage

[rtl/adc_iq_gain_mismatch_cal_unit.sv]
// ----------------------------------------------------------------------------
// adc_iq_gain_mismatch_cal_unit
// Per-chain I/Q power accumulators and a gain mismatch calculator that
// computes I and Q gain ratios for each active chain on a shared divider.
//
//   channel | ports                         | handshake
//   --------+-------------------------------+------------------------------
//   request | start, busy, req_data         | taken when start & !busy
//   result  | rsp_valid, rsp_data           | one-cycle strobe, no backpressure
//   csr     | csr_valid, csr_ready, csr_data| written when valid & ready
//
// Accumulate and clear transactions never raise busy.
// Calibrate handles each active chain in turn with two 32-step divisions
// on the shared divider, or skips them when a divisor sum is zero.
// Each result is registered before it appears. Synchronous reset
// clears the accumulators and sets the chain count to 3. Results cannot be
// stalled; the csr port is ready whenever the unit is not busy.
// ----------------------------------------------------------------------------
module adc_iq_gain_mismatch_cal_unit
   import iqgcal_pkg::*;
#(
   parameter int MAX_CHAINS = MAX_CHAINS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   // result
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   // csr
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [NUMCH_W-1:0] csr_data
);

   localparam int IDX_W = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
   localparam int CNT_W = $clog2(MAX_CHAINS + 1);

   cal_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [GAIN_W-1:0]  gi_ff, gi_in;
   logic [NUMCH_W-1:0] numch_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [ACC_W-1:0]   acc_i_odd_ff  [MAX_CHAINS];
   logic [ACC_W-1:0]   acc_i_even_ff [MAX_CHAINS];
   logic [ACC_W-1:0]   acc_q_odd_ff  [MAX_CHAINS];
   logic [ACC_W-1:0]   acc_q_even_ff [MAX_CHAINS];

   logic               accept;
   logic               acc_wr;
   logic [IDX_W-1:0]   rd_idx;
   logic [ACC_W-1:0]   rd_i_odd, rd_i_even, rd_q_odd, rd_q_even;
   logic [CNT_W-1:0]   active_cnt;
   logic               div_start;
   logic [ACC_W-1:0]   div_num, div_den;
   logic               div_done;
   logic [GAIN_W-1:0]  div_quot;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign acc_wr    = accept && (req_data.op == OP_ACCUM)
                      && (32'(req_data.chain) < MAX_CHAINS);

   // single read port: request chain when idle, walking chain when busy
   assign rd_idx    = busy ? k_ff : req_data.chain[IDX_W-1:0];
   assign rd_i_odd  = acc_i_odd_ff[rd_idx];
   assign rd_i_even = acc_i_even_ff[rd_idx];
   assign rd_q_odd  = acc_q_odd_ff[rd_idx];
   assign rd_q_even = acc_q_even_ff[rd_idx];

   // number of chains to report, saturated at the configured maximum
   always_comb begin
      if (32'(numch_ff) > MAX_CHAINS) begin
         active_cnt = CNT_W'(MAX_CHAINS);
      end else begin
         active_cnt = CNT_W'(numch_ff);
      end
   end

   // accumulators
   always_ff @(posedge clock) begin
      if (reset || (accept && (req_data.op == OP_CLEAR))) begin
         for (int c = 0; c < MAX_CHAINS; c++) begin
            acc_i_odd_ff[c]  <= '0;
            acc_i_even_ff[c] <= '0;
            acc_q_odd_ff[c]  <= '0;
            acc_q_even_ff[c] <= '0;
         end
      end else if (acc_wr) begin
         acc_i_odd_ff[rd_idx]  <= rd_i_odd  + req_data.meas_i_odd;
         acc_i_even_ff[rd_idx] <= rd_i_even + req_data.meas_i_even;
         acc_q_odd_ff[rd_idx]  <= rd_q_odd  + req_data.meas_q_odd;
         acc_q_even_ff[rd_idx] <= rd_q_even + req_data.meas_q_even;
      end
   end

   // chain count register
   always_ff @(posedge clock) begin
      if (reset) begin
         numch_ff <= NUMCH_RESET;
      end else if (csr_valid && csr_ready) begin
         numch_ff <= csr_data;
      end
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      gi_in        = gi_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_num      = rd_i_even;
      div_den      = rd_i_odd;
      rsp_in.out_chain   = CHAIN_W'(k_ff);
      rsp_in.enable_corr = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;
      rsp_in.last        = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.op == OP_CALIB) && (active_cnt != '0)) begin
               count_in = active_cnt;
               k_in     = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((rd_i_odd != '0) && (rd_q_even != '0)) begin
               div_start = 1'b1;
               state_in  = ST_DIV_I;
            end else begin
               // zero divisor: report without gains
               rsp_valid_in      = 1'b1;
               rsp_in.gain_field = '0;
               rsp_in.updated    = 1'b0;
               if (rsp_in.last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DIV_I: begin
            div_num = rd_q_odd;
            div_den = rd_q_even;
            if (div_done) begin
               gi_in     = div_quot;
               div_start = 1'b1;
               state_in  = ST_DIV_Q;
            end
         end
         ST_DIV_Q: begin
            if (div_done) begin
               rsp_valid_in      = 1'b1;
               rsp_in.gain_field = {gi_ff, div_quot};
               rsp_in.updated    = 1'b1;
               if (rsp_in.last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      gi_ff  <= gi_in;
      rsp_ff <= rsp_in;
   end

   // shared divider
   iqgcal_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (div_den),
      .div_done  (div_done),
      .div_quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/iqgcal_div.sv]
// ----------------------------------------------------------------------------
// iqgcal_div
// Shared restoring divider, one quotient bit per cycle. Divides the
// numerator scaled by 32 (mod 2^32) by the denominator and keeps the low
// gain bits of the quotient. The denominator must be nonzero.
// ----------------------------------------------------------------------------
module iqgcal_div
   import iqgcal_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              div_start,
   input  logic [ACC_W-1:0]  div_num,
   input  logic [ACC_W-1:0]  div_den,
   output logic              div_done,
   output logic [GAIN_W-1:0] div_quot
);

   localparam int CNT_W = $clog2(ACC_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [ACC_W-1:0]  dvd_ff, dvd_in;
   logic [ACC_W-1:0]  den_ff, den_in;
   logic [GAIN_W-1:0] quot_ff, quot_in;
   logic [ACC_W:0]    trial;

   // one restoring step: shift in the next dividend bit, try to subtract
   always_comb begin
      trial   = {rem_ff, dvd_ff[ACC_W-1]} - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ACC_W);
         rem_in  = '0;
         dvd_in  = {div_num[ACC_W-1-GAIN_SHIFT:0], GAIN_SHIFT'(0)};
         den_in  = div_den;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[ACC_W-2:0], 1'b0};
         if (trial[ACC_W]) begin
            rem_in  = {rem_ff[ACC_W-2:0], dvd_ff[ACC_W-1]};
            quot_in = {quot_ff[GAIN_W-2:0], 1'b0};
         end else begin
            rem_in  = trial[ACC_W-1:0];
            quot_in = {quot_ff[GAIN_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign div_done = done_ff;
   assign div_quot = quot_ff;

endmodule
